// ===== design/gregorian_date_advance_defines.svh =====
// Assertion macros shared by the date advance checker.
`ifndef GREGORIAN_DATE_ADVANCE_DEFINES_SVH
`define GREGORIAN_DATE_ADVANCE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GDA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gregorian_date_advance: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gregorian_date_advance: assertion failed");

`endif

// ===== design/gda_pkg.sv =====
// Types, field widths and calendar helpers for the Gregorian date advance block.
package gda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ADD_W   = 16;
    localparam int REM_W   = 7;

    // Reciprocal of 100 scaled by 2^24, rounded up; exact for years below 65536.
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

    localparam logic [REM_W:0]   CENTURY   = 8'd100;
    localparam logic [REM_W-1:0] LAST_REM  = 7'd99;
    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
    localparam logic [DAY_W-1:0] FIRST_DAY = 5'd1;
    localparam logic [DAY_W-1:0] LAST_DEC  = 5'd31;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [ADD_W-1:0]   days_to_add;
    } t_in_item;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic               start_valid;
        logic               year_overflow;
    } t_out_item;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_REM  = 6'b000100,
        S_CHK  = 6'b001000,
        S_STEP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // Days in a month; zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            FEBRUARY:                                    len = leap ? 5'd29 : 5'd28;
            default:                                     len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== design/gregorian_date_advance.sv =====
// Gregorian date advance: validity check and day-by-day stepping of a date.
//
//   channel   handshake          payload     direction
//   input     start / busy       i_item      in
//   result    o_done strobe      o_result    out
//
// Once an item is accepted, the year is multiplied by a reciprocal of 100, the remainder is
// formed and the start date is checked; then one day is stepped per cycle, and stepping
// stops early once the top year saturates.
// Reset returns the sequencer to idle. The result is shown for one cycle only and the
// receiver cannot stall it; busy stays high until that cycle has passed.
module gregorian_date_advance
    import gda_pkg::*;
#(
    parameter int MAX_YEAR = 9999,
    parameter int ADD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int YW = ($clog2(MAX_YEAR + 1) > YEAR_W) ? $clog2(MAX_YEAR + 1) : YEAR_W;
    localparam int CW = (ADD_BITS < ADD_W) ? ADD_BITS : ADD_W;
    localparam int PW = YW + RECIP_W;
    localparam int QW = PW - RECIP_SHIFT;
    localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

    t_state             r_state, n_state;
    logic [YW-1:0]      r_y, n_y;
    logic [MONTH_W-1:0] r_m, n_m;
    logic [DAY_W-1:0]   r_d, n_d;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [QW-1:0]      r_quo, n_quo;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [1:0]         r_q2, n_q2;
    logic               r_valid, n_valid;
    logic               r_ovf, n_ovf;

    logic               leap;
    logic [DAY_W-1:0]   mlen;
    logic               month_ok;
    logic [DAY_W:0]     day_inc;
    logic [PW-1:0]      quo_prod;

    // Year mod 4 equals the remainder mod 4 since 100 is a multiple of 4.
    assign leap     = (r_rem[1:0] == 2'd0) && ((r_rem != '0) || (r_q2 == 2'd0));
    assign mlen     = month_len(r_m, leap);
    assign month_ok = (r_m >= JANUARY) && (r_m <= DECEMBER);
    assign day_inc  = {1'b0, r_d} + (DAY_W+1)'(1);
    assign quo_prod = PW'(r_y) * PW'(RECIP_100);

    always_comb begin
        n_state = r_state;
        n_y     = r_y;
        n_m     = r_m;
        n_d     = r_d;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_q2    = r_q2;
        n_valid = r_valid;
        n_ovf   = r_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_y     = YW'(i_item.start_year);
                    n_m     = i_item.start_month;
                    n_d     = i_item.start_day;
                    n_cnt   = i_item.days_to_add[CW-1:0];
                    n_ovf   = 1'b0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo   = quo_prod[PW-1:RECIP_SHIFT];
                n_state = S_REM;
            end
            S_REM: begin
                // The remainder is below 128, so the low bits of the difference are exact.
                n_rem   = r_y[REM_W-1:0] - REM_W'(r_quo * CENTURY);
                n_q2    = r_quo[1:0];
                n_state = S_CHK;
            end
            S_CHK: begin
                n_valid = month_ok && (r_d != '0) && (r_d <= mlen);
                n_state = (r_cnt == '0) ? S_DONE : S_STEP;
            end
            S_STEP: begin
                n_cnt = r_cnt - CW'(1);
                if (month_ok && (day_inc <= {1'b0, mlen})) begin
                    n_d = day_inc[DAY_W-1:0];
                end else if (r_m < DECEMBER) begin
                    n_m = r_m + MONTH_W'(1);
                    n_d = FIRST_DAY;
                end else if (r_y >= MAX_Y) begin
                    n_y   = MAX_Y;
                    n_m   = DECEMBER;
                    n_d   = LAST_DEC;
                    n_ovf = 1'b1;
                end else begin
                    n_y = r_y + YW'(1);
                    n_m = JANUARY;
                    n_d = FIRST_DAY;
                    if (r_rem == LAST_REM) begin
                        n_rem = '0;
                        n_q2  = r_q2 + 2'd1;
                    end else begin
                        n_rem = r_rem + REM_W'(1);
                    end
                end
                if ((r_cnt == CW'(1)) || n_ovf) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y     <= n_y;
        r_m     <= n_m;
        r_d     <= n_d;
        r_cnt   <= n_cnt;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_q2    <= n_q2;
        r_valid <= n_valid;
        r_ovf   <= n_ovf;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_result.end_year      = r_y[YEAR_W-1:0];
        o_result.end_month     = r_m;
        o_result.end_day       = r_d;
        o_result.start_valid   = r_valid;
        o_result.year_overflow = r_ovf;
    end

endmodule

// ===== design/gda_checker.sv =====
// Port-level assertions for the Gregorian date advance block, with its bind.
`include "gregorian_date_advance_defines.svh"

module gda_checker
    import gda_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_done,
    input t_out_item o_result
);

    `GDA_ASSERT_IMPL(a_done_while_busy, o_done, busy)
    `GDA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy && !o_done)
    `GDA_ASSERT_NEXT(a_single_strobe, o_done, !o_done && !busy)
    `GDA_ASSERT_IMPL(a_overflow_date, o_done && o_result.year_overflow,
                     (o_result.end_month == DECEMBER) && (o_result.end_day == LAST_DEC))

endmodule

bind gregorian_date_advance gda_checker u_gda_checker (.*);
